### sv/mspt_pkg.sv
package mspt_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LIMIT_W  = 16;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned IN_DW    = 120;
	localparam int unsigned OUT_DW   = 72;

	localparam logic [TIME_W-1:0] MS_SCALE = 32'd1000;

	localparam logic MODE_LOOP = 1'b0;
	localparam logic MODE_POLL = 1'b1;

	typedef struct packed {
		logic capture;
		logic exec;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

### sv/multi_slot_periodic_timer.sv
// a result passes through the exec stage registers and then the output register
// a new item is taken only while the previous one commits, set by the read and the write-back
//   of one slot record (exec cycle, then commit cycle)
// a full output register that is not taken holds the commit cycle
// reset: arst_n clears loop time, token, slot flags and counters at once;
//   no clearing pass, the block accepts items as soon as reset is released
module multi_slot_periodic_timer
	import mspt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = 8
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// now_us[31:0] slot[35:32] repeat_time[67:36] repetition_limit[83:68]
	// delay_time[115:84] in_milliseconds[116] zero[119:117]
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// mode[0]
	input  logic [0:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// fired[0] run_count[32:1] elapsed_us[64:33] slot_finished[65] zero[71:66]
	output logic [OUT_DW-1:0] m_axis_tdata,
	// slot_error[0]
	output logic [0:0]        m_axis_tuser
);

	cmd_t cmd;
	sts_t sts;

	logic              fired, slot_error, slot_finished;
	logic [TIME_W-1:0] run_count, elapsed_us;

	mspt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mspt_dp #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_mode      (s_axis_tuser[0]),
		.in_now       (s_axis_tdata[31:0]),
		.in_slot      (s_axis_tdata[35:32]),
		.in_repeat    (s_axis_tdata[67:36]),
		.in_limit     (s_axis_tdata[83:68]),
		.in_delay     (s_axis_tdata[115:84]),
		.in_ms        (s_axis_tdata[116]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_fired    (fired),
		.out_error    (slot_error),
		.out_count    (run_count),
		.out_elapsed  (elapsed_us),
		.out_finished (slot_finished)
	);

	assign m_axis_tdata = {6'b0, slot_finished, elapsed_us, run_count, fired};
	assign m_axis_tuser = slot_error;

endmodule

### sv/mspt_ctrl.sv
module mspt_ctrl
	import mspt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready    = (state_q == ST_IDLE) || ((state_q == ST_COMMIT) && sts.out_free);
		cmd.capture = in_valid && in_ready;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.commit  = (state_q == ST_COMMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= in_valid ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_commit_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ($past(cmd.exec) || $past(state_q == ST_COMMIT)))
		else $error("commit without a preceding exec");
`endif

endmodule

### sv/mspt_dp.sv
module mspt_dp
	import mspt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = 8
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               in_mode,
	input  logic [TIME_W-1:0]  in_now,
	input  logic [SLOT_W-1:0]  in_slot,
	input  logic [TIME_W-1:0]  in_repeat,
	input  logic [LIMIT_W-1:0] in_limit,
	input  logic [TIME_W-1:0]  in_delay,
	input  logic               in_ms,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               out_fired,
	output logic               out_error,
	output logic [TIME_W-1:0]  out_count,
	output logic [TIME_W-1:0]  out_elapsed,
	output logic               out_finished
);

	localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [SLOT_W:0] NSLOTS = (SLOT_W + 1)'(TIMER_SLOTS);

	// captured item
	logic               mode_q;
	logic [TIME_W-1:0]  now_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  rep_time_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [TIME_W-1:0]  delay_q;
	logic               ms_q;

	// slot records
	logic [TIME_W-1:0]      loop_time_q;
	logic                   served_q;
	logic [TIMER_SLOTS-1:0] fin_q;
	logic [TIMER_SLOTS-1:0] first_q;
	logic [TIMER_SLOTS-1:0] cnt_q;
	logic [LIMIT_W-1:0]     repl_q  [TIMER_SLOTS];
	logic [TIME_W-1:0]      dlyl_q  [TIMER_SLOTS];
	logic [TIME_W-1:0]      start_q [TIMER_SLOTS];
	logic [TIME_W-1:0]      fcnt_q  [TIMER_SLOTS];
	logic [TIME_W-1:0]      last_q  [TIMER_SLOTS];

	// exec stage
	logic               mode_s1;
	logic               err_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [TIME_W-1:0]  per_s1;
	logic [TIME_W-1:0]  dly_s1;
	logic [LIMIT_W-1:0] lim_s1;
	logic               fin_s1;
	logic               first_s1;
	logic               cnt_s1;
	logic [LIMIT_W-1:0] repl_s1;
	logic [TIME_W-1:0]  dlyl_s1;
	logic [TIME_W-1:0]  fcnt_s1;
	logic [TIME_W-1:0]  last_s1;
	logic [TIME_W-1:0]  el_s1;

	logic [IDX_W-1:0] idx_c;

	logic poll_c, poll_ok_c, arm_c, meas_c, dly_done_c, fire_c, fin_set_c;
	logic               o_fired, o_error, o_fin;
	logic [TIME_W-1:0]  o_count, o_el;

	logic              out_valid_q;
	logic              fired_q, error_q, finished_q;
	logic [TIME_W-1:0] count_q, elapsed_q;

	assign idx_c = slot_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= in_mode;
			now_q      <= in_now;
			slot_q     <= in_slot;
			rep_time_q <= in_repeat;
			limit_q    <= in_limit;
			delay_q    <= in_delay;
			ms_q       <= in_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			mode_s1  <= mode_q;
			err_s1   <= ({1'b0, slot_q} >= NSLOTS);
			idx_s1   <= idx_c;
			now_s1   <= now_q;
			per_s1   <= ms_q ? TIME_W'(rep_time_q * MS_SCALE) : rep_time_q;
			dly_s1   <= ms_q ? TIME_W'(delay_q * MS_SCALE) : delay_q;
			lim_s1   <= limit_q;
			fin_s1   <= fin_q[idx_c];
			first_s1 <= first_q[idx_c];
			cnt_s1   <= cnt_q[idx_c];
			repl_s1  <= repl_q[idx_c];
			dlyl_s1  <= dlyl_q[idx_c];
			fcnt_s1  <= fcnt_q[idx_c];
			last_s1  <= last_q[idx_c];
			el_s1    <= loop_time_q - start_q[idx_c];
		end
	end

	always_comb begin
		poll_c     = (mode_s1 == MODE_POLL) && !err_s1;
		poll_ok_c  = cmd.commit && poll_c && !fin_s1;
		arm_c      = poll_ok_c && !cnt_s1;
		meas_c     = poll_ok_c && cnt_s1 && !served_q;
		dly_done_c = meas_c && (dlyl_s1 != '0) && (el_s1 >= dlyl_s1);
		fire_c     = meas_c && (dlyl_s1 == '0) && (el_s1 >= per_s1);
		fin_set_c  = fire_c && (repl_s1 == LIMIT_W'(1));

		o_error = (mode_s1 == MODE_POLL) && err_s1;
		o_fired = fire_c;
		o_count = '0;
		o_el    = '0;
		o_fin   = 1'b0;
		if (poll_c) begin
			o_count = fire_c ? fcnt_s1 + TIME_W'(1) : fcnt_s1;
			o_el    = meas_c ? el_s1 : last_s1;
			o_fin   = fin_s1 || fin_set_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_time_q <= '0;
			served_q    <= 1'b0;
			fin_q       <= '0;
			first_q     <= '1;
			cnt_q       <= '0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				fcnt_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (mode_s1 == MODE_LOOP) begin
				loop_time_q <= now_s1;
				served_q    <= 1'b0;
			end
			if (poll_ok_c && first_s1) begin
				first_q[idx_s1] <= 1'b0;
			end
			if (arm_c) begin
				cnt_q[idx_s1] <= 1'b1;
			end
			if (meas_c) begin
				last_q[idx_s1] <= el_s1;
			end
			if (fire_c) begin
				served_q        <= 1'b1;
				cnt_q[idx_s1]   <= 1'b0;
				fcnt_q[idx_s1]  <= fcnt_s1 + TIME_W'(1);
				fin_q[idx_s1]   <= fin_set_c;
			end
		end
	end

	// records without a reset value
	always_ff @(posedge clk) begin
		if (poll_ok_c && first_s1) begin
			repl_q[idx_s1] <= lim_s1;
			dlyl_q[idx_s1] <= dly_s1;
		end
		if (arm_c || dly_done_c) begin
			start_q[idx_s1] <= loop_time_q;
		end
		if (dly_done_c) begin
			dlyl_q[idx_s1] <= '0;
		end
		if (fire_c && (repl_s1 != '0)) begin
			repl_q[idx_s1] <= repl_s1 - LIMIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			fired_q    <= o_fired;
			error_q    <= o_error;
			count_q    <= o_count;
			elapsed_q  <= o_el;
			finished_q <= o_fin;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_fired     = fired_q;
	assign out_error     = error_q;
	assign out_count     = count_q;
	assign out_elapsed   = elapsed_q;
	assign out_finished  = finished_q;

`ifndef NO_ASSERTIONS
	a_fire_takes_token: assert property (@(posedge clk) disable iff (!arst_n)
		fire_c |=> served_q)
		else $error("firing did not take the loop token");

	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(~fin_q & $past(fin_q)) == '0)
		else $error("finished flag cleared");

	a_counting_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q & first_q) == '0)
		else $error("slot counting before its first poll");
`endif

endmodule
